/* rtl/lmp_pkg.sv */
// ----------------------------------------------------------------------------
// lmp_pkg
// Shared types, constants and the step function of the listener pose pipeline.
// ----------------------------------------------------------------------------
package lmp_pkg;

  localparam int LMP_SQRT_STEPS = 17;
  localparam int LMP_DIV_STEPS  = 17;
  localparam int LMP_STEPS      = LMP_SQRT_STEPS + LMP_DIV_STEPS;
  localparam int LMP_SPS        = 4;
  localparam int LMP_NSTG       = (LMP_STEPS + LMP_SPS - 1) / LMP_SPS;

  localparam logic [23:0] SCALE_RESET = 24'd65536;
  localparam logic        REG_SCALE   = 1'b0;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } lmp_branch_t;

  typedef struct packed {
    lmp_branch_t     sel;
    logic [32:0]     sq_x;
    logic [33:0]     sq_res;
    logic [2:0]      neg;
    logic [2:0][30:0] num;
    logic [2:0][16:0] quo;
    logic [2:0]      ovf;
    logic [2:0][44:0] pp_lo;
    logic [2:0][44:0] pp_hi;
    logic [2:0][57:0] pacc;
  } lmp_pipe_t;

  // One step of the shared sequence: square root steps first, then one
  // quotient bit for each of the three divisions.
  function automatic lmp_pipe_t lmp_step(lmp_pipe_t p, int k);
    lmp_pipe_t   q;
    logic [33:0] bit_v;
    logic [33:0] trial;
    logic [33:0] wsh;
    int          i;
    q = p;
    if (k < LMP_SQRT_STEPS) begin
      bit_v = 34'd1 << (2 * (LMP_SQRT_STEPS - 1 - k));
      trial = q.sq_res + bit_v;
      if ({1'b0, q.sq_x} >= trial) begin
        q.sq_x   = 33'({1'b0, q.sq_x} - trial);
        q.sq_res = (q.sq_res >> 1) + bit_v;
      end else begin
        q.sq_res = q.sq_res >> 1;
      end
    end else if (k < LMP_STEPS) begin
      i = LMP_STEPS - 1 - k;
      for (int j = 0; j < 3; j++) begin
        if (k == LMP_SQRT_STEPS) begin
          q.ovf[j] = ({4'b0, q.num[j]} >= {1'b0, q.sq_res[16:0], 17'b0});
        end
        wsh = 34'(q.sq_res[16:0]) << i;
        if ({3'b0, q.num[j]} >= wsh) begin
          q.num[j]    = 31'({3'b0, q.num[j]} - wsh);
          q.quo[j][i] = 1'b1;
        end
      end
    end
    return q;
  endfunction

endpackage

/* rtl/lmp_ifs.sv */
// ----------------------------------------------------------------------------
// lmp_ifs
// Matrix and pose channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface lmp_mtx_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [31:0] trans_x, trans_y, trans_z;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                trans_x, trans_y, trans_z, output ready);
endinterface

interface lmp_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  modport source (output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                  quat_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                quat_z, output ready);
endinterface

/* rtl/lmp_apb_regs.sv */
// ----------------------------------------------------------------------------
// lmp_apb_regs
// APB register file holding the scene scale factor.
// ----------------------------------------------------------------------------
module lmp_apb_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [23:0] scale
);
  import lmp_pkg::*;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SCALE)) begin
      scale <= pwdata[23:0];
    end
  end

  assign prdata = (paddr[2] == REG_SCALE) ? {8'b0, scale} : 32'b0;

endmodule

/* rtl/lmp_front.sv */
// ----------------------------------------------------------------------------
// lmp_front
// Entry stage: branch choice, radicand, quotient numerators, scale products.
// ----------------------------------------------------------------------------
module lmp_front (
  input  logic               clk,
  input  logic               rst,
  lmp_mtx_if.sink            mtx,
  input  logic [23:0]        scale,
  output logic               out_valid,
  input  logic               out_ready,
  output lmp_pkg::lmp_pipe_t out_data
);
  import lmp_pkg::*;

  logic signed [17:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, tr;
  logic signed [18:0] rad;
  logic signed [17:0] d [3];
  logic signed [31:0] t [3];
  lmp_pipe_t          nxt;

  always_comb begin
    a00 = 18'(mtx.m00); a01 = 18'(mtx.m01); a02 = 18'(mtx.m02);
    a10 = 18'(mtx.m10); a11 = 18'(mtx.m11); a12 = 18'(mtx.m12);
    a20 = 18'(mtx.m20); a21 = 18'(mtx.m21); a22 = 18'(mtx.m22);
    t[0] = mtx.trans_x; t[1] = mtx.trans_y; t[2] = mtx.trans_z;
    tr  = a00 + a11 + a22;
    nxt = '0;
    if (tr > 18'sd0) begin
      nxt.sel = BR_TRACE;
      rad  = 19'sd16384 + 19'(tr);
      d[0] = a12 - a21; d[1] = a20 - a02; d[2] = a01 - a10;
    end else if (a00 > a11 && a00 > a22) begin
      nxt.sel = BR_X;
      rad  = 19'sd16384 + 19'(a00) - 19'(a11) - 19'(a22);
      d[0] = a12 - a21; d[1] = -(a01 + a10); d[2] = -(a20 + a02);
    end else if (a11 > a22) begin
      nxt.sel = BR_Y;
      rad  = 19'sd16384 + 19'(a11) - 19'(a00) - 19'(a22);
      d[0] = a20 - a02; d[1] = -(a01 + a10); d[2] = -(a12 + a21);
    end else begin
      nxt.sel = BR_Z;
      rad  = 19'sd16384 + 19'(a22) - 19'(a00) - 19'(a11);
      d[0] = a01 - a10; d[1] = -(a20 + a02); d[2] = -(a12 + a21);
    end
    // clamp a negative radicand to zero
    nxt.sq_x = (rad < 19'sd0) ? 33'b0 : {rad[16:0], 16'b0};
    for (int j = 0; j < 3; j++) begin
      nxt.neg[j] = d[j][17];
      nxt.num[j] = d[j][17] ? {17'(-d[j]), 14'b0} : {d[j][16:0], 14'b0};
      nxt.pp_lo[j] = 45'(t[j] * $signed({1'b0, scale[11:0]}));
      nxt.pp_hi[j] = 45'(t[j] * $signed({1'b0, scale[23:12]}));
    end
  end

  assign mtx.ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mtx.ready) begin
      out_valid <= mtx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mtx.ready) begin
      out_data <= nxt;
    end
  end

endmodule

/* rtl/lmp_stage.sv */
// ----------------------------------------------------------------------------
// lmp_stage
// One pipeline stage: a few square root / quotient steps, position sum.
// ----------------------------------------------------------------------------
module lmp_stage #(
  parameter int STAGE = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmp_pkg::lmp_pipe_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lmp_pkg::lmp_pipe_t out_data
);
  import lmp_pkg::*;

  lmp_pipe_t nxt;

  always_comb begin
    nxt = in_data;
    for (int j = 0; j < LMP_SPS; j++) begin
      nxt = lmp_step(nxt, STAGE * LMP_SPS + j);
    end
    for (int a = 0; a < 3; a++) begin
      if (STAGE == 0) begin
        // merge the two partial products of the scale multiply
        nxt.pacc[a] = ({{13{in_data.pp_hi[a][44]}}, in_data.pp_hi[a]} << 12)
                    + {{13{in_data.pp_lo[a][44]}}, in_data.pp_lo[a]};
      end else if (STAGE == 1) begin
        // negate and add the rounding half
        nxt.pacc[a] = 58'd32768 - in_data.pacc[a];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= nxt;
    end
  end

endmodule

/* rtl/lmp_back.sv */
// ----------------------------------------------------------------------------
// lmp_back
// Output stage: saturation, quaternion placement, position shift and clamp.
// ----------------------------------------------------------------------------
module lmp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmp_pkg::lmp_pipe_t in_data,
  lmp_pose_if.source         pose
);
  import lmp_pkg::*;

  logic [16:0]  w;
  logic [15:0]  quarter;
  logic [15:0]  qv [3];
  logic [16:0]  mag;
  logic [31:0]  pv [3];
  logic [41:0]  sh;

  always_comb begin
    w       = in_data.sq_res[16:0];
    quarter = 16'(w >> 2);
    for (int j = 0; j < 3; j++) begin
      mag = in_data.ovf[j] ? 17'h1FFFF : in_data.quo[j];
      if (w == 17'd0) begin
        qv[j] = 16'd0;
      end else if (in_data.neg[j]) begin
        qv[j] = (mag >= 17'd32768) ? 16'h8000 : 16'd0 - {1'b0, mag[14:0]};
      end else begin
        qv[j] = (mag >= 17'd32767) ? 16'h7FFF : mag[15:0];
      end
      sh = in_data.pacc[j][57:16];
      if (sh[41:31] == {11{sh[41]}}) begin
        pv[j] = sh[31:0];
      end else begin
        pv[j] = sh[41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  assign in_ready = !pose.valid || pose.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose.valid <= 1'b0;
    end else if (in_ready) begin
      pose.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      pose.pos_x <= pv[0];
      pose.pos_y <= pv[1];
      pose.pos_z <= pv[2];
      case (in_data.sel)
        BR_TRACE: begin
          pose.quat_w <= quarter; pose.quat_x <= qv[0];
          pose.quat_y <= qv[1];   pose.quat_z <= qv[2];
        end
        BR_X: begin
          pose.quat_w <= qv[0];   pose.quat_x <= quarter;
          pose.quat_y <= qv[1];   pose.quat_z <= qv[2];
        end
        BR_Y: begin
          pose.quat_w <= qv[0];   pose.quat_x <= qv[1];
          pose.quat_y <= quarter; pose.quat_z <= qv[2];
        end
        default: begin
          pose.quat_w <= qv[0];   pose.quat_x <= qv[1];
          pose.quat_y <= qv[2];   pose.quat_z <= quarter;
        end
      endcase
    end
  end

endmodule

/* rtl/listener_matrix_to_pose.sv */
// ----------------------------------------------------------------------------
// listener_matrix_to_pose
// Inverted listener matrix to position and orientation quaternion.
// ----------------------------------------------------------------------------
// Channels: mtx carries the nine Q1.14 rotation entries and three Q16.16
// translation entries; pose returns the Q16.16 position (negated, scaled
// translation, saturated) and a Q1.14 quaternion. A transfer happens on a
// clock edge with valid and ready both high.
// Configuration: APB port, scale_factor (unsigned Q8.16) at byte address 0.
// Throughput: one transfer per cycle in and out while pose.ready stays high.
// Pipeline: the entry stage, nine stages of up to four square root / divide
// steps each (17 root steps then 17 quotient bits) and the output register.
// Stall: each stage holds while its successor is full and stalled; the
// input stays ready as long as any stage has a free slot, so bubbles fill.
// Reset: clears all stage valid bits and loads scale_factor with 1.0.
// ----------------------------------------------------------------------------
module listener_matrix_to_pose (
  input  logic        clk,
  input  logic        rst,
  lmp_mtx_if.sink     mtx,
  lmp_pose_if.source  pose,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lmp_pkg::*;

  logic [23:0] scale;

  // stage handshake chain: index 0 is the entry stage output
  logic      vld [LMP_NSTG + 1];
  logic      rdy [LMP_NSTG + 1];
  lmp_pipe_t dat [LMP_NSTG + 1];

  lmp_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .scale
  );

  lmp_front u_front (
    .clk, .rst, .mtx, .scale,
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_data  (dat[0])
  );

  for (genvar g = 0; g < LMP_NSTG; g++) begin : g_stage
    lmp_stage #(.STAGE(g)) u_stage (
      .clk, .rst,
      .in_valid  (vld[g]),
      .in_ready  (rdy[g]),
      .in_data   (dat[g]),
      .out_valid (vld[g + 1]),
      .out_ready (rdy[g + 1]),
      .out_data  (dat[g + 1])
    );
  end

  lmp_back u_back (
    .clk, .rst,
    .in_valid (vld[LMP_NSTG]),
    .in_ready (rdy[LMP_NSTG]),
    .in_data  (dat[LMP_NSTG]),
    .pose
  );

  // drop every valid bit on reset (checked here on the entry stage and on pose)
  a_reset_empty: assert property (@(posedge clk) rst |=> !pose.valid && !vld[0])
    else $error("pipeline not empty after reset");

  a_reset_scale: assert property (@(posedge clk) rst |=> scale == SCALE_RESET)
    else $error("scale not reset to 1.0");

  // input can only be blocked when the whole chain is full and stalled
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !mtx.ready |-> pose.valid && !pose.ready && vld[LMP_NSTG])
    else $error("input blocked while pipeline has room");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_SCALE) |=>
    scale == $past(pwdata[23:0]))
    else $error("scale write lost");

endmodule
